// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared immediate-implication and next-cycle checks, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/blm_pkg.sv =====
// ----------------------------------------------------------------------------
// blm_pkg
// Types and constants shared by the battery level monitor modules.
// ----------------------------------------------------------------------------
package blm_pkg;

  localparam int WINDOW      = 32;
  localparam int SAMPLE_BITS = 12;
  localparam int CODE_W      = 12;
  localparam int SLOT_W      = $clog2(WINDOW);
  localparam int SUM_W       = SAMPLE_BITS + SLOT_W;
  localparam int CHG_W       = 7;
  localparam int SPAN_W      = 6;
  localparam int NUM_W       = SPAN_W + CODE_W;
  localparam int QUO_W       = 6;
  localparam int IDX_W       = 3;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_WARNING  = 2'd1;
  localparam status_t ST_LOW      = 2'd2;
  localparam status_t ST_CRITICAL = 2'd3;

  // register indexes
  localparam logic [IDX_W-1:0] REG_FULL     = 3'd0;
  localparam logic [IDX_W-1:0] REG_NOMINAL  = 3'd1;
  localparam logic [IDX_W-1:0] REG_WARN     = 3'd2;
  localparam logic [IDX_W-1:0] REG_LOW      = 3'd3;
  localparam logic [IDX_W-1:0] REG_CRITICAL = 3'd4;

  localparam logic [CODE_W-1:0] FULL_RST     = 12'd1421;
  localparam logic [CODE_W-1:0] NOMINAL_RST  = 12'd1252;
  localparam logic [CODE_W-1:0] WARN_RST     = 12'd1184;
  localparam logic [CODE_W-1:0] LOW_RST      = 12'd1117;
  localparam logic [CODE_W-1:0] CRITICAL_RST = 12'd1015;

  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  num;
    logic [CODE_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

endpackage

// ===== src/blm_div.sv =====
// ----------------------------------------------------------------------------
// blm_div
// Restoring divider, one quotient bit per cycle. Quotient must fit QUO_W bits.
// ----------------------------------------------------------------------------
module blm_div (
  input  logic              clk,
  input  logic              rst_n,
  input  blm_pkg::div_req_t req,
  output blm_pkg::div_rsp_t rsp
);
  import blm_pkg::*;

  localparam int CNT_W = $clog2(QUO_W);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [NUM_W-1:0]  rem_r;
  logic [NUM_W-1:0]  dsr_r;
  logic [QUO_W-1:0]  quo_r;
  logic              ge;
  logic [NUM_W-1:0]  rem_sub;

  assign ge      = (rem_r >= dsr_r);
  assign rem_sub = rem_r - dsr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(QUO_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.num;
      dsr_r <= NUM_W'(req.den) << (QUO_W - 1);
      quo_r <= '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_sub;
      end
      quo_r <= {quo_r[QUO_W-2:0], ge};
      dsr_r <= dsr_r >> 1;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

// ===== src/battery_level_monitor_unit.sv =====
// ----------------------------------------------------------------------------
// battery_level_monitor_unit
// Path from input transaction to out_valid: S_SUM, S_EVAL, S_MUL, then the
//   bit-serial divider in S_DIV for the charge segment, then S_DONE.
// One item at a time: a new input is taken only after S_DONE has passed it on.
// Reset (sync, rst_n low): thresholds to defaults, ring treated as all zero
//   via a fill flag, sum, slot, status and lamp state cleared.
// ----------------------------------------------------------------------------
module battery_level_monitor_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [11:0]                 in_adc_sample,
  input  logic                        in_blink_phase,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [11:0]                 out_average_code,
  output logic [6:0]                  out_charge_percent,
  output logic [1:0]                  out_level_status,
  output logic                        out_status_changed,
  output logic                        out_green_lamp,
  output logic                        out_red_lamp,
  output logic                        out_buzzer_on,
  // configuration write channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [blm_pkg::IDX_W-1:0]   cfg_index,
  input  logic [blm_pkg::CODE_W-1:0]  cfg_data
);
  import blm_pkg::*;
  `include "assert_macros.svh"

  // one item in flight: sum -> classify -> multiply -> divide -> output
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SUM  = 6'b000010,
    S_EVAL = 6'b000100,
    S_MUL  = 6'b001000,
    S_DIV  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // threshold registers
  logic [CODE_W-1:0] full_r, nom_r, warn_r, low_r, crit_r;

  // sample ring: sync RAM with a registered read
  logic [SAMPLE_BITS-1:0] ring_mem [WINDOW];
  logic [SAMPLE_BITS-1:0] rd_data_r;
  logic                   wrapped_r;   // every slot written at least once
  logic [SLOT_W-1:0]      slot_r;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [SAMPLE_BITS-1:0] sample_r;
  logic                   phase_r;
  logic [SAMPLE_BITS-1:0] old_sample;

  // per-item status state
  status_t last_status_r;
  logic    green_state_r, red_state_r;
  logic    changed_r, buzz_r;

  // classification
  logic [CODE_W-1:0] avg_c, avg_r;
  status_t           status_c;
  logic [CHG_W-1:0]  base_c, base_r;
  logic [SPAN_W-1:0] span_c, span_r;
  logic [CODE_W-1:0] diff_c, diff_r;
  logic [CODE_W-1:0] den_c, den_r;
  logic              green_nxt, red_nxt, buzz_nxt;

  logic [CHG_W-1:0]  charge_r;

  // output register
  logic              out_valid_r;
  logic              out_free;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign out_free  = !out_valid_r || out_ready;

  // --- configuration -------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= FULL_RST;
      nom_r  <= NOMINAL_RST;
      warn_r <= WARN_RST;
      low_r  <= LOW_RST;
      crit_r <= CRITICAL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FULL:     full_r <= cfg_data;
        REG_NOMINAL:  nom_r  <= cfg_data;
        REG_WARN:     warn_r <= cfg_data;
        REG_LOW:      low_r  <= cfg_data;
        REG_CRITICAL: crit_r <= cfg_data;
        default: ;    // indexes past the list are dropped
      endcase
    end
  end

  // --- FSM -----------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_SUM;
      S_SUM:  state_nxt = S_EVAL;
      S_EVAL: state_nxt = S_MUL;
      S_MUL:  state_nxt = S_DIV;
      S_DIV:  if (div_rsp.done) state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // --- ring read / write ---------------------------------------------------
  // Read of the slot to be replaced is issued on the accepting edge; the
  // write-back follows in S_SUM. Items never overlap, so no forwarding.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      rd_data_r <= ring_mem[slot_r];
    end
    if (state_r == S_SUM) begin
      ring_mem[slot_r] <= sample_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sample_r <= in_adc_sample[SAMPLE_BITS-1:0];
      phase_r  <= in_blink_phase;
    end
  end

  // never-written slots read as the reset value, zero
  assign old_sample = wrapped_r ? rd_data_r : '0;
  assign sum_nxt    = sum_r - SUM_W'(old_sample) + SUM_W'(sample_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r     <= '0;
      slot_r    <= '0;
      wrapped_r <= 1'b0;
    end else if (state_r == S_SUM) begin
      sum_r <= sum_nxt;
      if (slot_r == SLOT_W'(WINDOW - 1)) begin
        slot_r    <= '0;
        wrapped_r <= 1'b1;
      end else begin
        slot_r <= slot_r + 1'b1;
      end
    end
  end

  // --- classification ------------------------------------------------------
  assign avg_c = CODE_W'(sum_r >> SLOT_W);

  always_comb begin
    if (avg_c >= warn_r) begin
      status_c = ST_OK;
    end else if (avg_c >= low_r) begin
      status_c = ST_WARNING;
    end else if (avg_c >= crit_r) begin
      status_c = ST_LOW;
    end else begin
      status_c = ST_CRITICAL;
    end
  end

  // Charge segment. Saturated cases divide zero by one. Each reachable
  // segment has a positive span, whatever the threshold order.
  always_comb begin
    base_c = '0;
    span_c = '0;
    diff_c = '0;
    den_c  = CODE_W'(1);
    if (avg_c >= full_r) begin
      base_c = CHG_W'(100);
    end else if (avg_c <= crit_r) begin
      base_c = '0;
    end else if (avg_c >= nom_r) begin
      base_c = CHG_W'(50);
      span_c = SPAN_W'(50);
      diff_c = avg_c - nom_r;
      den_c  = full_r - nom_r;
    end else if (avg_c >= warn_r) begin
      base_c = CHG_W'(20);
      span_c = SPAN_W'(30);
      diff_c = avg_c - warn_r;
      den_c  = nom_r - warn_r;
    end else if (avg_c >= low_r) begin
      base_c = CHG_W'(5);
      span_c = SPAN_W'(15);
      diff_c = avg_c - low_r;
      den_c  = warn_r - low_r;
    end else begin
      base_c = '0;
      span_c = SPAN_W'(5);
      diff_c = avg_c - crit_r;
      den_c  = low_r - crit_r;
    end
  end

  // lamps: green steady in ok, blinking in warning; red steady in low,
  // blinking in critical; buzzer follows the phase in critical only
  always_comb begin
    green_nxt = 1'b0;
    red_nxt   = 1'b0;
    buzz_nxt  = 1'b0;
    case (status_c)
      ST_OK: begin
        green_nxt = 1'b1;
      end
      ST_WARNING: begin
        green_nxt = !green_state_r;
      end
      ST_LOW: begin
        red_nxt = 1'b1;
      end
      default: begin
        red_nxt  = !red_state_r;
        buzz_nxt = phase_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_status_r <= ST_OK;
      green_state_r <= 1'b0;
      red_state_r   <= 1'b0;
    end else if (state_r == S_EVAL) begin
      last_status_r <= status_c;
      green_state_r <= green_nxt;
      red_state_r   <= red_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EVAL) begin
      avg_r     <= avg_c;
      base_r    <= base_c;
      span_r    <= span_c;
      diff_r    <= diff_c;
      den_r     <= den_c;
      changed_r <= (status_c != last_status_r);
      buzz_r    <= buzz_nxt;
    end
  end

  // --- charge division -----------------------------------------------------
  // product registered inside the divider on the start cycle
  assign div_req.start = (state_r == S_MUL);
  assign div_req.num   = NUM_W'(span_r) * NUM_W'(diff_r);
  assign div_req.den   = den_r;

  blm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if ((state_r == S_DIV) && div_rsp.done) begin
      charge_r <= base_r + CHG_W'(div_rsp.quo);
    end
  end

  // --- output register -----------------------------------------------------
  // holds a finished transaction while the next item is taken in
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_DONE) && out_free) begin
      out_average_code   <= avg_r;
      out_charge_percent <= charge_r;
      out_level_status   <= last_status_r;
      out_status_changed <= changed_r;
      out_green_lamp     <= green_state_r;
      out_red_lamp       <= red_state_r;
      out_buzzer_on      <= buzz_r;
    end
  end

  assign out_valid = out_valid_r;

  // --- checks --------------------------------------------------------------
  `ASSERT_IMP(a_lamps_excl, out_valid, !(out_green_lamp && out_red_lamp), "both lamps lit")
  `ASSERT_IMP(a_buzz_crit, out_valid && out_buzzer_on, out_level_status == ST_CRITICAL,
              "buzzer outside critical")
  `ASSERT_IMP(a_charge_rng, out_valid, out_charge_percent <= CHG_W'(100), "charge above 100")
  `ASSERT_NXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken while busy")

endmodule
